// ===== src/rlsb_pkg.sv =====
// ----------------------------------------------------------------------------
// rlsb_pkg
// Shared types and constants for the rectangle/bound subtraction block.
// ----------------------------------------------------------------------------
package rlsb_pkg;

   localparam int COORD_W     = 16;
   localparam int CSR_INDEX_W = 8;
   localparam int QUEUE_DEPTH = 4;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_BOUND_LEFT   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BOUND_TOP    = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BOUND_RIGHT  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BOUND_BOTTOM = 8'd3;

   // piece kinds, bit positions in the piece mask, in emission order
   localparam int PIECE_TOP    = 0;
   localparam int PIECE_BOTTOM = 1;
   localparam int PIECE_LEFT   = 2;
   localparam int PIECE_RIGHT  = 3;
   localparam int PIECE_PASS   = 4;
   localparam int NUM_KINDS    = 5;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type left;
      coord_type top;
      coord_type right;
      coord_type bottom;
   } rect_type;

   typedef logic [NUM_KINDS-1:0] mask_type;

   // one classified transaction waiting for the back end
   typedef struct packed {
      rect_type rect;
      mask_type mask;
   } entry_type;

endpackage

// ===== src/rlsb_front.sv =====
// ----------------------------------------------------------------------------
// rlsb_front
// Classifies an accepted rectangle against the bound and registers it.
// ----------------------------------------------------------------------------
module rlsb_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  rlsb_pkg::rect_type   rect,
   input  rlsb_pkg::rect_type   bound,
   output logic                 push,
   output rlsb_pkg::entry_type  entry
);

   logic                 valid_ff;
   logic                 valid_in;
   rlsb_pkg::entry_type  entry_ff;
   rlsb_pkg::entry_type  entry_in;
   logic                 touch;

   always_comb begin
      touch = (bound.right >= rect.left) && (bound.bottom >= rect.top) &&
              (bound.left <= rect.right) && (bound.top <= rect.bottom);
      entry_in.rect = rect;
      entry_in.mask = '0;
      if (touch) begin
         entry_in.mask[rlsb_pkg::PIECE_TOP]    = rect.top < bound.top;
         entry_in.mask[rlsb_pkg::PIECE_BOTTOM] = rect.bottom > bound.bottom;
         entry_in.mask[rlsb_pkg::PIECE_LEFT]   = rect.left < bound.left;
         entry_in.mask[rlsb_pkg::PIECE_RIGHT]  = rect.right > bound.right;
      end else begin
         entry_in.mask[rlsb_pkg::PIECE_PASS] = 1'b1;
      end
      valid_in = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

   assign push  = valid_ff;
   assign entry = entry_ff;

endmodule

// ===== src/rlsb_queue.sv =====
// ----------------------------------------------------------------------------
// rlsb_queue
// Small FIFO of classified transactions between front and back end.
// ----------------------------------------------------------------------------
module rlsb_queue #(
   parameter int DEPTH = rlsb_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  rlsb_pkg::entry_type           push_entry,
   input  logic                          pop,
   output rlsb_pkg::entry_type           head,
   output logic                          empty,
   output logic [$clog2(DEPTH+1)-1:0]    count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   rlsb_pkg::entry_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head  = slot_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

endmodule

// ===== src/rlsb_back.sv =====
// ----------------------------------------------------------------------------
// rlsb_back
// Walks the piece mask of one transaction, one result piece per cycle.
// ----------------------------------------------------------------------------
module rlsb_back (
   input  logic                 clock,
   input  logic                 reset,
   input  rlsb_pkg::rect_type   bound,
   input  rlsb_pkg::entry_type  head,
   input  logic                 empty,
   output logic                 pop,
   output logic                 rsp_valid,
   output rlsb_pkg::rect_type   rsp_piece,
   output logic                 rsp_last
);

   logic                 active_ff, active_in;
   rlsb_pkg::rect_type   rect_ff, rect_in;
   rlsb_pkg::mask_type   rem_ff, rem_in;
   rlsb_pkg::mask_type   sel;
   rlsb_pkg::mask_type   rem_next;
   logic                 emit;
   logic                 take;
   rlsb_pkg::coord_type  row_top;
   rlsb_pkg::coord_type  row_bottom;
   rlsb_pkg::rect_type   piece;

   logic                 valid_ff;
   rlsb_pkg::rect_type   piece_ff;
   logic                 last_ff;

   // lowest set bit wins: top, bottom, left, right, pass
   assign sel      = rem_ff & (~rem_ff + 1'b1);
   assign rem_next = rem_ff & ~sel;
   assign emit     = active_ff && (rem_ff != '0);
   assign take     = !empty && (!active_ff || (rem_next == '0));

   always_comb begin
      // rows left over once the bands are cut away
      row_top    = rect_ff.top;
      row_bottom = rect_ff.bottom;
      if (rem_ff[rlsb_pkg::PIECE_TOP] == 1'b0 &&
          rect_ff.top < bound.top) begin
         row_top = bound.top;
      end
      if (rem_ff[rlsb_pkg::PIECE_BOTTOM] == 1'b0 &&
          rect_ff.bottom > bound.bottom) begin
         row_bottom = bound.bottom;
      end

      piece = rect_ff;
      if (sel[rlsb_pkg::PIECE_TOP]) begin
         piece.bottom = bound.top - 1'b1;
      end else if (sel[rlsb_pkg::PIECE_BOTTOM]) begin
         piece.top = bound.bottom + 1'b1;
      end else if (sel[rlsb_pkg::PIECE_LEFT]) begin
         piece.top    = row_top;
         piece.bottom = row_bottom;
         piece.right  = bound.left - 1'b1;
      end else if (sel[rlsb_pkg::PIECE_RIGHT]) begin
         piece.top    = row_top;
         piece.bottom = row_bottom;
         piece.left   = bound.right + 1'b1;
      end

      active_in = active_ff;
      rect_in   = rect_ff;
      rem_in    = rem_next;
      if (take) begin
         active_in = 1'b1;
         rect_in   = head.rect;
         rem_in    = head.mask;
      end else if (rem_next == '0) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         rem_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         rem_ff    <= rem_in;
         valid_ff  <= emit;
      end
      rect_ff <= rect_in;
      if (emit) begin
         piece_ff <= piece;
         last_ff  <= (rem_next == '0);
      end
   end

   assign pop       = take;
   assign rsp_valid = valid_ff;
   assign rsp_piece = piece_ff;
   assign rsp_last  = last_ff;

endmodule

// ===== src/rect_list_subtract_bound.sv =====
// ----------------------------------------------------------------------------
// rect_list_subtract_bound
// Subtracts a configured bound rectangle from a stream of rectangles.
// ----------------------------------------------------------------------------
// Usage:
//   Input transaction: req_rect_* is taken at a rising edge with start high
//   and busy low. Each transaction yields one pass-through rectangle when it
//   misses the bound, else zero to four pieces (top band, bottom band, left
//   strip, right strip). Coordinates are inclusive, 16-bit signed.
//   Results: rsp_valid strobes for one cycle per piece; rsp_last_piece marks
//   the final piece of a transaction. The receiver cannot stall, so pieces
//   leave at one per cycle as soon as they are formed.
//   Path: an accepted rectangle passes the classify register, the queue write,
//   the back-end load and the piece register before its first piece strobes.
//   Throughput: the back end emits one piece per cycle and moves to the next
//   queued transaction without a gap. A fully covered rectangle occupies the
//   back end without a strobe.
//   busy rises when the queue plus the classify stage hold QUEUE_DEPTH
//   transactions; the front keeps accepting while the back end works.
//   Configuration: csr_index/csr_wdata written when csr_valid is high;
//   csr_ready is always high. Indexes past the bound registers are ignored.
//   Write the bound only while the block is idle.
//   Reset (synchronous): queue emptied, no strobes, bound cleared to zero.
// ----------------------------------------------------------------------------
module rect_list_subtract_bound #(
   parameter int QUEUE_DEPTH = rlsb_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // input transactions
   input  logic                                start,
   output logic                                busy,
   input  logic signed [rlsb_pkg::COORD_W-1:0] req_rect_left,
   input  logic signed [rlsb_pkg::COORD_W-1:0] req_rect_top,
   input  logic signed [rlsb_pkg::COORD_W-1:0] req_rect_right,
   input  logic signed [rlsb_pkg::COORD_W-1:0] req_rect_bottom,
   // results
   output logic                                rsp_valid,
   output logic signed [rlsb_pkg::COORD_W-1:0] rsp_piece_left,
   output logic signed [rlsb_pkg::COORD_W-1:0] rsp_piece_top,
   output logic signed [rlsb_pkg::COORD_W-1:0] rsp_piece_right,
   output logic signed [rlsb_pkg::COORD_W-1:0] rsp_piece_bottom,
   output logic                                rsp_last_piece,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rlsb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rlsb_pkg::COORD_W-1:0]        csr_wdata
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

   rlsb_pkg::rect_type   bound_ff;
   rlsb_pkg::rect_type   bound_in;
   rlsb_pkg::rect_type   req_rect;
   rlsb_pkg::rect_type   rsp_piece;
   rlsb_pkg::entry_type  front_entry;
   rlsb_pkg::entry_type  queue_head;
   logic                 front_push;
   logic                 queue_pop;
   logic                 accept;
   logic [CNT_W-1:0]     level;
   logic                 queue_empty;
   logic [CNT_W-1:0]     queue_count;

   // bound registers
   always_comb begin
      bound_in = bound_ff;
      if (csr_valid) begin
         case (csr_index)
            rlsb_pkg::REG_BOUND_LEFT:   bound_in.left   = csr_wdata;
            rlsb_pkg::REG_BOUND_TOP:    bound_in.top    = csr_wdata;
            rlsb_pkg::REG_BOUND_RIGHT:  bound_in.right  = csr_wdata;
            rlsb_pkg::REG_BOUND_BOTTOM: bound_in.bottom = csr_wdata;
            default:                    bound_in = bound_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff <= '0;
      end else begin
         bound_ff <= bound_in;
      end
   end

   assign csr_ready = 1'b1;

   // the transaction in the classify stage always finds a queue slot
   assign level  = queue_count + CNT_W'(front_push);
   assign busy   = (level >= CNT_W'(QUEUE_DEPTH));
   assign accept = start && !busy;

   assign req_rect.left   = req_rect_left;
   assign req_rect.top    = req_rect_top;
   assign req_rect.right  = req_rect_right;
   assign req_rect.bottom = req_rect_bottom;

   rlsb_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .rect   (req_rect),
      .bound  (bound_ff),
      .push   (front_push),
      .entry  (front_entry)
   );

   rlsb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .push_entry (front_entry),
      .pop        (queue_pop),
      .head       (queue_head),
      .empty      (queue_empty),
      .count      (queue_count)
   );

   rlsb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .bound     (bound_ff),
      .head      (queue_head),
      .empty     (queue_empty),
      .pop       (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_piece (rsp_piece),
      .rsp_last  (rsp_last_piece)
   );

   assign rsp_piece_left   = rsp_piece.left;
   assign rsp_piece_top    = rsp_piece.top;
   assign rsp_piece_right  = rsp_piece.right;
   assign rsp_piece_bottom = rsp_piece.bottom;

endmodule

// ===== test/rect_list_subtract_bound_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_list_subtract_bound_checker
// Watches the request, result and CSR channels of the block, predicts the
// pieces for each accepted rectangle and compares them in order.
// ----------------------------------------------------------------------------
module rect_list_subtract_bound_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic signed [rlsb_pkg::COORD_W-1:0] req_rect_left,
   input  logic signed [rlsb_pkg::COORD_W-1:0] req_rect_top,
   input  logic signed [rlsb_pkg::COORD_W-1:0] req_rect_right,
   input  logic signed [rlsb_pkg::COORD_W-1:0] req_rect_bottom,
   input  logic                                rsp_valid,
   input  logic signed [rlsb_pkg::COORD_W-1:0] rsp_piece_left,
   input  logic signed [rlsb_pkg::COORD_W-1:0] rsp_piece_top,
   input  logic signed [rlsb_pkg::COORD_W-1:0] rsp_piece_right,
   input  logic signed [rlsb_pkg::COORD_W-1:0] rsp_piece_bottom,
   input  logic                                rsp_last_piece,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [rlsb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rlsb_pkg::COORD_W-1:0]        csr_wdata,
   output int                                  fail_count,
   output int                                  pending_pieces
);

   typedef struct packed {
      rlsb_pkg::rect_type rect;
      logic               last;
   } piece_type;

   rlsb_pkg::rect_type  bound;
   piece_type           expected_pieces[$];
   int                  mismatches = 0;

   function automatic piece_type make_piece(rlsb_pkg::coord_type l, rlsb_pkg::coord_type t,
                                            rlsb_pkg::coord_type r, rlsb_pkg::coord_type b);
      piece_type p;
      p.rect.left   = l;
      p.rect.top    = t;
      p.rect.right  = r;
      p.rect.bottom = b;
      p.last        = 1'b0;
      return p;
   endfunction

   // bound subtraction; pieces go out top, bottom, left, right
   function automatic void subtract_bound(rlsb_pkg::rect_type r);
      piece_type found[$];
      rlsb_pkg::coord_type rows_top;
      rlsb_pkg::coord_type rows_bottom;
      rows_top    = r.top;
      rows_bottom = r.bottom;
      if (!(bound.right >= r.left && bound.bottom >= r.top &&
            bound.left <= r.right && bound.top <= r.bottom)) begin
         found.push_back(make_piece(r.left, r.top, r.right, r.bottom));
      end else begin
         if (r.top < bound.top) begin
            found.push_back(make_piece(r.left, r.top, r.right, bound.top - 16'sd1));
            rows_top = bound.top;
         end
         if (r.bottom > bound.bottom) begin
            found.push_back(make_piece(r.left, bound.bottom + 16'sd1, r.right, r.bottom));
            rows_bottom = bound.bottom;
         end
         if (r.left < bound.left)
            found.push_back(make_piece(r.left, rows_top, bound.left - 16'sd1, rows_bottom));
         if (r.right > bound.right)
            found.push_back(make_piece(bound.right + 16'sd1, rows_top, r.right, rows_bottom));
      end
      if (found.size() > 0)
         found[found.size()-1].last = 1'b1;
      foreach (found[i])
         expected_pieces.push_back(found[i]);
   endfunction

   function automatic void check_field(string name, int expected, int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      piece_type           exp_piece;
      rlsb_pkg::rect_type  req;
      if (reset) begin
         bound = '0;
         expected_pieces.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rlsb_pkg::REG_BOUND_LEFT:   bound.left   = rlsb_pkg::coord_type'(csr_wdata);
               rlsb_pkg::REG_BOUND_TOP:    bound.top    = rlsb_pkg::coord_type'(csr_wdata);
               rlsb_pkg::REG_BOUND_RIGHT:  bound.right  = rlsb_pkg::coord_type'(csr_wdata);
               rlsb_pkg::REG_BOUND_BOTTOM: bound.bottom = rlsb_pkg::coord_type'(csr_wdata);
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_pieces.size() == 0) begin
               $error("unexpected piece (%0d,%0d)-(%0d,%0d) last=%0b", rsp_piece_left,
                      rsp_piece_top, rsp_piece_right, rsp_piece_bottom, rsp_last_piece);
               mismatches++;
            end else begin
               exp_piece = expected_pieces.pop_front();
               check_field("piece_left",   int'(exp_piece.rect.left),   int'(rsp_piece_left));
               check_field("piece_top",    int'(exp_piece.rect.top),    int'(rsp_piece_top));
               check_field("piece_right",  int'(exp_piece.rect.right),  int'(rsp_piece_right));
               check_field("piece_bottom", int'(exp_piece.rect.bottom), int'(rsp_piece_bottom));
               check_field("last_piece",   int'(exp_piece.last),        int'(rsp_last_piece));
            end
         end
         if (start && !busy) begin
            req.left   = req_rect_left;
            req.top    = req_rect_top;
            req.right  = req_rect_right;
            req.bottom = req_rect_bottom;
            subtract_bound(req);
         end
      end
      pending_pieces <= expected_pieces.size();
      fail_count     <= mismatches;
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the bound-rectangle subtraction block: directed corner cases,
// then random rectangles clustered around a series of bound settings.
// ----------------------------------------------------------------------------
module tb;

   // anything past the last bound register must be ignored by the block
   localparam int FIRST_UNUSED_INDEX = int'(rlsb_pkg::REG_BOUND_BOTTOM) + 1;
   localparam int MAX_INDEX          = (1 << rlsb_pkg::CSR_INDEX_W) - 1;
   // classify + queue + piece register, plus a full queue of 4-piece work
   localparam int DRAIN_CYCLES       = 4 * rlsb_pkg::QUEUE_DEPTH + 8;
   localparam int NUM_PHASES         = 10;
   localparam int ITEMS_PER_PHASE    = 24;
   localparam int COORD_MIN          = -32768;
   localparam int COORD_MAX          = 32767;
   localparam time RUN_LIMIT         = 400_000;

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   rlsb_pkg::coord_type               req_rect_left;
   rlsb_pkg::coord_type               req_rect_top;
   rlsb_pkg::coord_type               req_rect_right;
   rlsb_pkg::coord_type               req_rect_bottom;
   logic                              rsp_valid;
   rlsb_pkg::coord_type               rsp_piece_left;
   rlsb_pkg::coord_type               rsp_piece_top;
   rlsb_pkg::coord_type               rsp_piece_right;
   rlsb_pkg::coord_type               rsp_piece_bottom;
   logic                              rsp_last_piece;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [rlsb_pkg::CSR_INDEX_W-1:0]  csr_index;
   logic [rlsb_pkg::COORD_W-1:0]      csr_wdata;
   int                                fail_count;
   int                                pending_pieces;

   // current bound as programmed: left, top, right, bottom
   int bound_now[4];
   bit idle_on;

   rect_list_subtract_bound DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_rect_left    (req_rect_left),
      .req_rect_top     (req_rect_top),
      .req_rect_right   (req_rect_right),
      .req_rect_bottom  (req_rect_bottom),
      .rsp_valid        (rsp_valid),
      .rsp_piece_left   (rsp_piece_left),
      .rsp_piece_top    (rsp_piece_top),
      .rsp_piece_right  (rsp_piece_right),
      .rsp_piece_bottom (rsp_piece_bottom),
      .rsp_last_piece   (rsp_last_piece),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   rect_list_subtract_bound_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_rect_left    (req_rect_left),
      .req_rect_top     (req_rect_top),
      .req_rect_right   (req_rect_right),
      .req_rect_bottom  (req_rect_bottom),
      .rsp_valid        (rsp_valid),
      .rsp_piece_left   (rsp_piece_left),
      .rsp_piece_top    (rsp_piece_top),
      .rsp_piece_right  (rsp_piece_right),
      .rsp_piece_bottom (rsp_piece_bottom),
      .rsp_last_piece   (rsp_last_piece),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_pieces   (pending_pieces)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop in case a transaction or a piece never shows up
   initial begin
      #RUN_LIMIT;
      $display("** rect_list_subtract_bound: FAILED **");
      $finish;
   end

   function automatic rlsb_pkg::rect_type rect(int l, int t, int r, int b);
      rlsb_pkg::rect_type x;
      x.left   = rlsb_pkg::coord_type'(l);
      x.top    = rlsb_pkg::coord_type'(t);
      x.right  = rlsb_pkg::coord_type'(r);
      x.bottom = rlsb_pkg::coord_type'(b);
      return x;
   endfunction

   function automatic int clamp_coord(int v);
      if (v < COORD_MIN) return COORD_MIN;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   // Random rectangle. Columns cluster around the bound's columns and rows
   // around its rows so that every piece combination comes up; a share of
   // coordinates is full-range or pinned to the extremes, and some
   // rectangles are left inverted.
   function automatic rlsb_pkg::rect_type random_rect();
      int c[4];
      int tmp;
      int sel;
      foreach (c[i]) begin
         sel = $urandom_range(0, 9);
         if (sel < 2)
            c[i] = int'($urandom_range(0, 65535)) + COORD_MIN;
         else if (sel == 2)
            c[i] = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
         else
            c[i] = clamp_coord(bound_now[(i % 2) + 2 * $urandom_range(0, 1)]
                               + int'($urandom_range(0, 40)) - 20);
      end
      if ($urandom_range(0, 6) != 0) begin
         if (c[0] > c[2]) begin tmp = c[0]; c[0] = c[2]; c[2] = tmp; end
         if (c[1] > c[3]) begin tmp = c[1]; c[1] = c[3]; c[3] = tmp; end
      end
      return rect(c[0], c[1], c[2], c[3]);
   endfunction

   // one CSR transaction; csr_valid stays up for back-to-back writes
   task automatic write_csr(int index, int data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= rlsb_pkg::CSR_INDEX_W'(index);
      csr_wdata <= rlsb_pkg::COORD_W'(data);
      do @(posedge clock); while (!csr_ready);
   endtask

   // program all four bound registers, with a stray write to a dead index
   task automatic set_bound(int l, int t, int r, int b);
      write_csr($urandom_range(FIRST_UNUSED_INDEX, MAX_INDEX), $urandom_range(0, 65535));
      write_csr(int'(rlsb_pkg::REG_BOUND_LEFT),   l);
      write_csr(int'(rlsb_pkg::REG_BOUND_TOP),    t);
      write_csr(int'(rlsb_pkg::REG_BOUND_RIGHT),  r);
      write_csr(int'(rlsb_pkg::REG_BOUND_BOTTOM), b);
      @(negedge clock);
      csr_valid <= 1'b0;
      bound_now = '{l, t, r, b};
   endtask

   // one input transaction, optionally followed by an idle burst with start low
   task automatic send_rect(rlsb_pkg::rect_type x, bit may_idle);
      @(negedge clock);
      start           <= 1'b1;
      req_rect_left   <= x.left;
      req_rect_top    <= x.top;
      req_rect_right  <= x.right;
      req_rect_bottom <= x.bottom;
      do @(posedge clock); while (busy);
      if (may_idle && $urandom_range(0, 2) == 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, 8)) @(negedge clock);
      end
   endtask

   // Block goes quiet: all expected pieces seen, then extra cycles since a
   // fully covered rectangle still occupies the pipeline without a strobe.
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_pieces != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int cx;
      int cy;
      int l;
      int t;
      int r;
      int b;
      rlsb_pkg::rect_type x;

      reset           = 1'b1;
      start           = 1'b0;
      req_rect_left   = '0;
      req_rect_top    = '0;
      req_rect_right  = '0;
      req_rect_bottom = '0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      bound_now       = '{0, 0, 0, 0};
      idle_on         = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // bound at reset is the single point (0,0)
      send_rect(rect(-1, -1, 1, 1), 1'b0);                  // all four pieces
      send_rect(rect(0, 0, 0, 0), 1'b0);                    // exactly covered
      send_rect(rect(1, 0, 5, 0), 1'b0);                    // misses by one column
      send_rect(rect(0, -3, 0, 3), 1'b1);                   // top and bottom bands
      wait_drained();

      // directed cases against a mid-sized bound
      set_bound(-100, -50, 100, 50);
      send_rect(rect(-300, -20, -101, 20), 1'b0);           // miss on the left
      send_rect(rect(-20, -200, 20, -51), 1'b0);            // miss above
      send_rect(rect(101, 51, 300, 300), 1'b0);             // miss below right
      send_rect(rect(-10, -10, 10, 10), 1'b0);              // fully covered
      send_rect(rect(-100, -50, 100, 50), 1'b0);            // equals the bound
      send_rect(rect(-200, -100, 200, 100), 1'b0);          // encloses the bound
      send_rect(rect(-20, -80, 20, 10), 1'b0);              // top band only
      send_rect(rect(-20, 10, 20, 90), 1'b0);               // bottom band only
      send_rect(rect(-150, -10, 10, 10), 1'b0);             // left strip only
      send_rect(rect(10, -10, 150, 10), 1'b0);              // right strip only
      send_rect(rect(100, -10, 200, 10), 1'b0);             // touches on the right edge
      send_rect(rect(-200, 50, -100, 90), 1'b0);            // touches at a corner
      send_rect(rect(-32768, -32768, 32767, 32767), 1'b0);  // full plane
      send_rect(rect(32767, 32767, 32767, 32767), 1'b0);    // extreme corner, miss
      send_rect(rect(-32768, -32768, -32768, -32768), 1'b0);
      send_rect(rect(50, 10, -50, -10), 1'b0);              // inverted, covered
      send_rect(rect(-150, 40, 150, -40), 1'b0);            // inverted, two strips
      send_rect(rect(300, -60, -300, 60), 1'b0);            // inverted, passes through
      send_rect(rect(-150, 60, 150, -60), 1'b0);
      send_rect(rect(-32768, 32767, 32767, -32768), 1'b1);  // inverted extremes
      wait_drained();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         cx = int'($urandom_range(0, 60000)) - 30000;
         cy = int'($urandom_range(0, 60000)) - 30000;
         l  = cx - int'($urandom_range(0, 300));
         r  = cx + int'($urandom_range(0, 300));
         t  = cy - int'($urandom_range(0, 300));
         b  = cy + int'($urandom_range(0, 300));
         case (phase)
            2:       set_bound(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
            4:       set_bound(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
            6:       set_bound(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
            7:       set_bound(r, b, l, t);                  // inverted bound
            default: set_bound(l, t, r, b);
         endcase
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // idle bursts come and go; the final phase runs back to back
            if (i % 8 == 0)
               idle_on = (phase != NUM_PHASES - 1) && ($urandom_range(0, 2) != 0);
            x = random_rect();
            send_rect(x, idle_on);
         end
         wait_drained();
      end

      if (fail_count == 0)
         $display("** rect_list_subtract_bound: PASSED **");
      else
         $display("** rect_list_subtract_bound: FAILED **");
      $finish;
   end

endmodule

// ===== rect_list_subtract_bound.f =====
src/rlsb_pkg.sv
src/rlsb_front.sv
src/rlsb_queue.sv
src/rlsb_back.sv
src/rect_list_subtract_bound.sv
test/rect_list_subtract_bound_checker.sv
test/tb.sv
